### rtl/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [2:0] {
        FUNC_ADD    = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_GET    = 3'd2,
        FUNC_MAP    = 3'd3,
        FUNC_REPLY  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        KIND_OK      = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_ENTRY   = 3'd2,
        KIND_NONE    = 3'd3,
        KIND_DELTA   = 3'd4,
        KIND_READ    = 3'd5,
        KIND_DONE    = 3'd6
    } kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] match;
        logic              enabled;
        logic              active;
    } entry_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] match;
        logic              enabled;
        logic [BYTE_W-1:0] delta;
        logic              last;
    } result_t;

endpackage
`default_nettype wire

### rtl/mrpt_out_fifo.sv
`default_nettype none
// small result queue between the sequencer and the output channel
module mrpt_out_fifo
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mrpt_pkg::result_t push_data,
    output logic                  empty,
    output logic [2:0]            level,
    input  wire logic             pop,
    output mrpt_pkg::result_t     head
);
    mrpt_pkg::result_t mem_reg [4];
    logic [1:0] rd_reg;
    logic [1:0] wr_reg;
    logic [2:0] cnt_reg;

    assign empty = (cnt_reg == 3'd0);
    assign level = cnt_reg;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end
endmodule
`default_nettype wire

### rtl/memory_read_patch_table.sv
`default_nettype none
// Patch table with a memory-matching map walk. Entries live in one
// synchronous memory with a registered read. An item is taken only while the
// sequencer is idle and at most one result is waiting in the four-deep result
// queue, so a stalled output holds off the input. remove compacts the table
// in place. map and read reply step forward entry by entry until the next
// enabled entry inside the range, first clearing an active entry; a reply
// also checks the entry that the walk stopped at before moving on.
// The entry memory has no reset; only positions below the count are read.
module memory_read_patch_table
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [15:0] patch_address,
    input  wire logic [7:0]  patch_value,
    input  wire logic [7:0]  patch_match,
    input  wire logic        patch_enabled,
    input  wire logic [5:0]  entry_index,
    input  wire logic [15:0] range_start,
    input  wire logic [15:0] range_end,
    input  wire logic [7:0]  read_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [15:0]      out_address,
    output logic [7:0]       out_value,
    output logic [7:0]       out_match,
    output logic             out_enabled,
    output logic [7:0]       delta,
    output logic             last
);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // one-hot sequencer states
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_GETR  = 9'b000000010,
        ST_RMRD  = 9'b000000100,
        ST_RMCK  = 9'b000001000,
        ST_SCRD  = 9'b000010000,
        ST_SCCK  = 9'b000100000,
        ST_RPRD  = 9'b001000000,
        ST_RPCK  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // entry memory
    mrpt_pkg::entry_t mem [TABLE_DEPTH];
    mrpt_pkg::entry_t rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    mrpt_pkg::entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control and captured item
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] rm_reg, rm_next;
    logic [CW-1:0] wptr_reg, wptr_next;
    logic          busy_reg, busy_next;
    logic [15:0]   start_reg, start_next;
    logic [15:0]   end_reg, end_next;
    logic [15:0]   key_addr_reg;
    logic [7:0]    key_value_reg;
    logic [7:0]    key_match_reg;
    logic [7:0]    data_reg;

    // result queue
    mrpt_pkg::result_t push_data, head;
    logic push, empty, pop;
    logic [2:0] level;

    mrpt_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .empty     (empty),
        .level     (level),
        .pop       (pop),
        .head      (head)
    );

    assign out_valid   = !empty;
    assign pop         = out_valid && !out_stall;
    assign kind        = head.kind;
    assign out_address = head.address;
    assign out_value   = head.value;
    assign out_match   = head.match;
    assign out_enabled = head.enabled;
    assign delta       = head.delta;
    assign last        = head.last;

    // an item may queue up to three results
    logic room;
    assign room     = (level <= 3'd1);
    assign in_stall = !((state_reg == ST_IDLE) && room);
    logic accept;
    assign accept   = in_valid && !in_stall;

    logic in_scope;
    assign in_scope = rd_data_reg.enabled && (rd_data_reg.addr >= start_reg)
                      && (rd_data_reg.addr <= end_reg);

    function automatic mrpt_pkg::result_t mk(input logic [2:0] k,
                                             input logic [15:0] a,
                                             input logic [7:0] d,
                                             input logic l);
        mrpt_pkg::result_t r;
        r         = '0;
        r.kind    = k;
        r.address = a;
        r.delta   = d;
        r.last    = l;
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        rm_next    = rm_reg;
        wptr_next  = wptr_reg;
        busy_next  = busy_reg;
        start_next = start_reg;
        end_next   = end_reg;
        rd_en      = 1'b0;
        rd_addr    = scan_reg[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = count_reg[IW-1:0];
        wr_data    = '0;
        push       = 1'b0;
        push_data  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        mrpt_pkg::FUNC_ADD:
                        begin
                            push = 1'b1;
                            if (count_reg >= DEPTH_C)
                            begin
                                push_data = mk(mrpt_pkg::KIND_FULL, '0, '0, 1'b1);
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_data.addr    = patch_address;
                                wr_data.value   = patch_value;
                                wr_data.match   = patch_match;
                                wr_data.enabled = patch_enabled;
                                wr_data.active  = 1'b0;
                                count_next      = count_reg + CW'(1);
                                push_data = mk(mrpt_pkg::KIND_OK, '0, '0, 1'b1);
                            end
                        end
                        mrpt_pkg::FUNC_REMOVE:
                        begin
                            // own read pointer so a running walk keeps its place
                            rm_next    = '0;
                            wptr_next  = '0;
                            state_next = ST_RMRD;
                        end
                        mrpt_pkg::FUNC_GET:
                        begin
                            if ({{(32-6){1'b0}}, entry_index} < 32'(count_reg))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IW'(entry_index);
                                state_next = ST_GETR;
                            end
                            else
                            begin
                                push      = 1'b1;
                                push_data = mk(mrpt_pkg::KIND_NONE, '0, '0, 1'b1);
                            end
                        end
                        mrpt_pkg::FUNC_MAP:
                        begin
                            start_next = range_start;
                            end_next   = range_end;
                            busy_next  = 1'b1;
                            scan_next  = '0;
                            state_next = ST_SCRD;
                        end
                        mrpt_pkg::FUNC_REPLY:
                        begin
                            if (busy_reg)
                            begin
                                state_next = ST_RPRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_GETR:
            begin
                push              = 1'b1;
                push_data         = '0;
                push_data.kind    = mrpt_pkg::KIND_ENTRY;
                push_data.address = rd_data_reg.addr;
                push_data.value   = rd_data_reg.value;
                push_data.match   = rd_data_reg.match;
                push_data.enabled = rd_data_reg.enabled;
                push_data.last    = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_RMRD:
            begin
                if (rm_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rm_reg[IW-1:0];
                    state_next = ST_RMCK;
                end
                else
                begin
                    count_next = wptr_reg;
                    push       = 1'b1;
                    push_data  = mk(mrpt_pkg::KIND_OK, '0, '0, 1'b1);
                    state_next = ST_IDLE;
                end
            end
            ST_RMCK:
            begin
                // keep entries that do not match, compacted to the write pointer
                if (!(rd_data_reg.addr == key_addr_reg &&
                      rd_data_reg.value == key_value_reg &&
                      rd_data_reg.match == key_match_reg))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = wptr_reg[IW-1:0];
                    wr_data   = rd_data_reg;
                    wptr_next = wptr_reg + CW'(1);
                end
                rm_next    = rm_reg + CW'(1);
                state_next = ST_RMRD;
            end
            ST_RPRD:
            begin
                if (scan_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_RPCK;
                end
                else
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = ST_SCRD;
                end
            end
            ST_RPCK:
            begin
                if (in_scope && rd_data_reg.match == data_reg)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = scan_reg[IW-1:0];
                    wr_data        = rd_data_reg;
                    wr_data.active = 1'b1;
                    push           = 1'b1;
                    push_data      = mk(mrpt_pkg::KIND_DELTA, rd_data_reg.addr,
                                        rd_data_reg.value - data_reg, 1'b0);
                end
                scan_next  = scan_reg + CW'(1);
                state_next = ST_SCRD;
            end
            ST_SCRD:
            begin
                if (scan_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SCCK;
                end
                else
                begin
                    scan_next  = '0;
                    busy_next  = 1'b0;
                    push       = 1'b1;
                    push_data  = mk(mrpt_pkg::KIND_DONE, '0, '0, 1'b1);
                    state_next = ST_IDLE;
                end
            end
            ST_SCCK:
            begin
                if (in_scope)
                begin
                    if (rd_data_reg.active)
                    begin
                        // clear the old delta first, then ask for the byte
                        wr_en          = 1'b1;
                        wr_addr        = scan_reg[IW-1:0];
                        wr_data        = rd_data_reg;
                        wr_data.active = 1'b0;
                        push           = 1'b1;
                        push_data      = mk(mrpt_pkg::KIND_DELTA, rd_data_reg.addr,
                                            '0, 1'b0);
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_data  = mk(mrpt_pkg::KIND_READ, rd_data_reg.addr,
                                        '0, 1'b1);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = ST_SCRD;
                end
            end
            ST_DONE:
            begin
                push       = 1'b1;
                push_data  = mk(mrpt_pkg::KIND_READ, rd_data_reg.addr, '0, 1'b1);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_addr_reg  <= patch_address;
            key_value_reg <= patch_value;
            key_match_reg <= patch_match;
            data_reg      <= read_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            rm_reg    <= '0;
            wptr_reg  <= '0;
            busy_reg  <= 1'b0;
            start_reg <= '0;
            end_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            rm_reg    <= rm_next;
            wptr_reg  <= wptr_next;
            busy_reg  <= busy_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end
endmodule
`default_nettype wire
